[sv/led_strip_bit_transposer_macros.svh]
// Assertion macros shared by the checker of the LED strip bit transposer.
`ifndef LED_STRIP_BIT_TRANSPOSER_MACROS_SVH
`define LED_STRIP_BIT_TRANSPOSER_MACROS_SVH
// Checked at every rising clock edge while reset is released.
`define LBT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every rising clock edge, during reset as well.
`define LBT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`endif

[sv/lbt_pkg.sv]
// Constants and types shared by the LED strip bit transposer modules.
package lbt_pkg;

  localparam int unsigned MAX_LEDS_PER_STRIP = 256;
  localparam int unsigned PACKET_BYTES       = 64;
  localparam int unsigned STRIPS             = 8;
  localparam int unsigned COLORS             = 3;
  localparam int unsigned BYTE_BITS          = 8;
  localparam int unsigned LATCH_BYTES        = 64;
  localparam int unsigned STORE_DEPTH        = COLORS * STRIPS * MAX_LEDS_PER_STRIP;

  localparam int unsigned ADDR_W     = 13;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned CFG_W      = 9;
  localparam int unsigned CFG_RESET  = 1;
  localparam int unsigned STORE_AW   = $clog2(STORE_DEPTH);
  localparam int unsigned GROUP_W    = $clog2(COLORS * MAX_LEDS_PER_STRIP + 1);
  localparam int unsigned PKT_GROUPS = PACKET_BYTES / BYTE_BITS;
  localparam int unsigned FILL_W     = $clog2(PACKET_BYTES);
  localparam int unsigned LATCH_W    = $clog2(LATCH_BYTES);
  localparam int unsigned BIT_W      = $clog2(BYTE_BITS);
  localparam int unsigned STRIP_W    = $clog2(STRIPS);

  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int unsigned CMD_CNT_W = $clog2(CMD_DEPTH + 1);
  localparam int unsigned RES_DEPTH = 2;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  typedef enum logic [1:0] {
    CMD_FETCH   = 2'd0,
    CMD_STORE   = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [ADDR_W-1:0]   addr;
    logic [DATA_W-1:0]   value;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] out_byte;
    logic              packet_end;
    logic              frame_last;
  } result_t;

endpackage

[sv/lbt_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module lbt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/lbt_front.sv]
// Front end: accepts requests, classifies them and queues them as commands.
module lbt_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic                        req_type_i,
  input  logic [lbt_pkg::ADDR_W-1:0]  load_address_i,
  input  logic [lbt_pkg::DATA_W-1:0]  load_value_i,
  output lbt_pkg::cmd_t               cmd_o,
  output logic                        cmd_valid_o,
  input  logic                        cmd_take_i
);

  lbt_pkg::cmd_t                   q_mem_q [lbt_pkg::CMD_DEPTH];
  logic [lbt_pkg::CMD_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [lbt_pkg::CMD_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [lbt_pkg::CMD_CNT_W-1:0]   cnt_q, cnt_d;
  lbt_pkg::cmd_t                   cmd_in;
  logic                            do_push, do_pop;

  // A load outside the store still restarts the output, it just stores nothing.
  always_comb begin
    cmd_in.addr  = load_address_i;
    cmd_in.value = load_value_i;
    if (req_type_i == lbt_pkg::REQ_FETCH) begin
      cmd_in.kind = lbt_pkg::CMD_FETCH;
    end else if (load_address_i < lbt_pkg::ADDR_W'(lbt_pkg::STORE_DEPTH)) begin
      cmd_in.kind = lbt_pkg::CMD_STORE;
    end else begin
      cmd_in.kind = lbt_pkg::CMD_RESTART;
    end
  end

  assign full_o      = (cnt_q == lbt_pkg::CMD_CNT_W'(lbt_pkg::CMD_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_take_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == lbt_pkg::CMD_PTR_W'(lbt_pkg::CMD_DEPTH - 1)) ? '0
                                                                          : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == lbt_pkg::CMD_PTR_W'(lbt_pkg::CMD_DEPTH - 1)) ? '0
                                                                          : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

[sv/lbt_back.sv]
// Back end: frame store, gather sequencer, bit-plane output and result queue.
module lbt_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lbt_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  lbt_pkg::cmd_t               cmd_i,
  input  logic                        cmd_valid_i,
  output logic                        cmd_take_o,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic [lbt_pkg::DATA_W-1:0]  out_byte_o,
  output logic                        packet_end_o,
  output logic                        frame_last_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_GATHER = 3'b010,
    ST_DRAIN  = 3'b100
  } state_e;

  function automatic logic [lbt_pkg::DATA_W-1:0] reverse_byte(
    input logic [lbt_pkg::DATA_W-1:0] v
  );
    logic [lbt_pkg::DATA_W-1:0] r;
    for (int k = 0; k < lbt_pkg::DATA_W; k++) begin
      r[k] = v[lbt_pkg::DATA_W-1-k];
    end
    return r;
  endfunction

  state_e                            state_q, state_d;
  logic [lbt_pkg::CFG_W-1:0]         cfg_q;
  logic [lbt_pkg::CFG_W-1:0]         n_sat;
  logic [lbt_pkg::GROUP_W-1:0]       n3, limit;
  logic [lbt_pkg::GROUP_W-1:0]       group_q, group_d;
  logic [lbt_pkg::BIT_W-1:0]         bit_q, bit_d;
  logic [lbt_pkg::FILL_W-1:0]        fill_q, fill_d;
  logic [lbt_pkg::LATCH_W-1:0]       latch_q, latch_d, latch_cur;
  logic                              in_latch_q, in_latch_d;
  logic                              have_q, have_d;
  logic [lbt_pkg::STORE_AW-1:0]      rd_addr_q, rd_addr_d;
  logic [lbt_pkg::STRIP_W-1:0]       rd_cnt_q, rd_cnt_d;
  logic                              rd_issue;
  logic                              rvld_q;
  logic [lbt_pkg::STRIP_W-1:0]       ridx_q;
  logic [lbt_pkg::DATA_W-1:0]        gath_q [lbt_pkg::STRIPS];
  logic [lbt_pkg::STRIPS-1:0]        plane;

  logic                              ram_we;
  logic [lbt_pkg::DATA_W-1:0]        ram_rdata;

  lbt_pkg::result_t                  res_mem_q [lbt_pkg::RES_DEPTH];
  logic [lbt_pkg::RES_PTR_W-1:0]     res_wr_q, res_rd_q;
  logic [lbt_pkg::RES_CNT_W-1:0]     res_cnt_q;
  logic                              res_push, res_pop, res_space;
  lbt_pkg::result_t                  res_data;

  // The count saturates at MAX_LEDS_PER_STRIP; 3*n is the stride between strips.
  assign n_sat = (cfg_q > lbt_pkg::CFG_W'(lbt_pkg::MAX_LEDS_PER_STRIP))
               ? lbt_pkg::CFG_W'(lbt_pkg::MAX_LEDS_PER_STRIP) : cfg_q;
  assign n3    = lbt_pkg::GROUP_W'(n_sat * lbt_pkg::COLORS);
  assign limit = lbt_pkg::GROUP_W'((n3 / lbt_pkg::PKT_GROUPS) * lbt_pkg::PKT_GROUPS);

  always_comb begin
    for (int l = 0; l < lbt_pkg::STRIPS; l++) begin
      plane[l] = gath_q[l][bit_q];
    end
  end

  assign latch_cur = in_latch_q ? latch_q : '0;
  assign res_space = (res_cnt_q != lbt_pkg::RES_CNT_W'(lbt_pkg::RES_DEPTH));

  always_comb begin
    state_d    = state_q;
    group_d    = group_q;
    bit_d      = bit_q;
    fill_d     = fill_q;
    latch_d    = latch_q;
    in_latch_d = in_latch_q;
    have_d     = have_q;
    rd_addr_d  = rd_addr_q;
    rd_cnt_d   = rd_cnt_q;
    rd_issue   = 1'b0;
    cmd_take_o = 1'b0;
    ram_we     = 1'b0;
    res_push   = 1'b0;
    res_data   = '0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            lbt_pkg::CMD_STORE, lbt_pkg::CMD_RESTART: begin
              ram_we     = (cmd_i.kind == lbt_pkg::CMD_STORE);
              cmd_take_o = 1'b1;
              group_d    = '0;
              bit_d      = '0;
              fill_d     = '0;
              latch_d    = '0;
              in_latch_d = 1'b0;
              have_d     = 1'b0;
            end
            lbt_pkg::CMD_FETCH: begin
              if (res_space) begin
                if (in_latch_q || (group_q >= limit)) begin
                  cmd_take_o = 1'b1;
                  res_push   = 1'b1;
                  if (latch_cur == lbt_pkg::LATCH_W'(lbt_pkg::LATCH_BYTES - 1)) begin
                    res_data.packet_end = 1'b1;
                    res_data.frame_last = 1'b1;
                    group_d    = '0;
                    bit_d      = '0;
                    fill_d     = '0;
                    latch_d    = '0;
                    in_latch_d = 1'b0;
                    have_d     = 1'b0;
                  end else begin
                    in_latch_d = 1'b1;
                    latch_d    = latch_cur + 1'b1;
                  end
                end else if ((bit_q != '0) || have_q) begin
                  cmd_take_o          = 1'b1;
                  res_push            = 1'b1;
                  have_d              = 1'b0;
                  res_data.out_byte   = plane;
                  res_data.packet_end =
                    (fill_q == lbt_pkg::FILL_W'(lbt_pkg::PACKET_BYTES - 1));
                  fill_d = res_data.packet_end ? '0 : fill_q + 1'b1;
                  bit_d  = bit_q + 1'b1;
                  if (bit_q == lbt_pkg::BIT_W'(lbt_pkg::BYTE_BITS - 1)) begin
                    group_d = group_q + 1'b1;
                  end
                end else begin
                  state_d   = ST_GATHER;
                  rd_addr_d = lbt_pkg::STORE_AW'(group_q);
                  rd_cnt_d  = '0;
                end
              end
            end
            default: begin
              cmd_take_o = 1'b1;
            end
          endcase
        end
      end
      ST_GATHER: begin
        rd_issue  = 1'b1;
        rd_addr_d = rd_addr_q + lbt_pkg::STORE_AW'(n3);
        rd_cnt_d  = rd_cnt_q + 1'b1;
        if (rd_cnt_q == lbt_pkg::STRIP_W'(lbt_pkg::STRIPS - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_IDLE;
        have_d  = 1'b1;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cfg_q      <= lbt_pkg::CFG_W'(lbt_pkg::CFG_RESET);
      group_q    <= '0;
      bit_q      <= '0;
      fill_q     <= '0;
      latch_q    <= '0;
      in_latch_q <= 1'b0;
      have_q     <= 1'b0;
      rd_cnt_q   <= '0;
      rvld_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      group_q    <= group_d;
      bit_q      <= bit_d;
      fill_q     <= fill_d;
      latch_q    <= latch_d;
      in_latch_q <= in_latch_d;
      have_q     <= have_d;
      rd_cnt_q   <= rd_cnt_d;
      rvld_q     <= rd_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr_d;
    ridx_q    <= rd_cnt_q;
    if (rvld_q) begin
      gath_q[ridx_q] <= reverse_byte(8'h80 | ram_rdata);
    end
  end

  lbt_ram #(
    .WIDTH (lbt_pkg::DATA_W),
    .DEPTH (lbt_pkg::STORE_DEPTH)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cmd_i.addr[lbt_pkg::STORE_AW-1:0]),
    .wdata_i (cmd_i.value),
    .raddr_i (rd_addr_q),
    .rdata_o (ram_rdata)
  );

  // Result queue.
  assign empty_o  = (res_cnt_q == '0);
  assign res_pop  = pop_i && !empty_o;
  assign out_byte_o   = res_mem_q[res_rd_q].out_byte;
  assign packet_end_o = res_mem_q[res_rd_q].packet_end;
  assign frame_last_o = res_mem_q[res_rd_q].frame_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wr_q  <= '0;
      res_rd_q  <= '0;
      res_cnt_q <= '0;
    end else begin
      if (res_push) begin
        res_wr_q <= (res_wr_q == lbt_pkg::RES_PTR_W'(lbt_pkg::RES_DEPTH - 1)) ? '0
                                                                             : res_wr_q + 1'b1;
      end
      if (res_pop) begin
        res_rd_q <= (res_rd_q == lbt_pkg::RES_PTR_W'(lbt_pkg::RES_DEPTH - 1)) ? '0
                                                                             : res_rd_q + 1'b1;
      end
      if (res_push && !res_pop) begin
        res_cnt_q <= res_cnt_q + 1'b1;
      end else if (res_pop && !res_push) begin
        res_cnt_q <= res_cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_mem_q[res_wr_q] <= res_data;
    end
  end

endmodule

[sv/led_strip_bit_transposer.sv]
// Top level of the LED strip bit transposer: front end, back end and their wiring.
//
// This block turns a frame of RGB bytes for eight LED strips into the bit-plane
// byte stream of a parallel strip driver. A load request stores one color byte
// in the 6144-byte frame store and restarts the output at the first byte of the
// frame; a fetch request returns the next output byte. For each LED and color
// the eight strips' bytes are gathered, bit 7 is forced high, and eight bytes
// are sent in which bit l of byte b is bit (7-b) of strip l's byte. Only whole
// 64-byte packets are sent, then 64 zero latch bytes, the last of which carries
// frame_last, after which the frame starts over. Requests enter through a
// two-deep command queue, and results leave through a two-deep result queue, so
// both sides stall independently. The back end handles a load or a fetch of a
// latch byte directly, and a fetch of a data byte as well, except the first of
// each group of eight, which first runs a gather: a start step, eight reads
// through the single read port of the frame store, and a step to catch the
// last read. At the earliest, a request passes the command queue and the result
// queue registers before its result is on the outputs, where it can be popped.
// The frame store is not cleared; each entry must be loaded before a fetch
// reads it. leds_per_strip above 256 acts as 256.
module led_strip_bit_transposer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration: LEDs on each strip.
  input  logic                        cfg_we_i,
  input  logic [lbt_pkg::CFG_W-1:0]   cfg_wdata_i,
  // Request queue side.
  input  logic                        push,
  output logic                        full,
  input  logic                        req_type_i,
  input  logic [lbt_pkg::ADDR_W-1:0]  load_address_i,
  input  logic [lbt_pkg::DATA_W-1:0]  load_value_i,
  // Result queue side.
  output logic                        empty,
  input  logic                        pop,
  output logic [lbt_pkg::DATA_W-1:0]  out_byte_o,
  output logic                        packet_end_o,
  output logic                        frame_last_o
);

  // Commands travel in request order, so a load never overtakes a fetch that
  // was accepted before it.
  lbt_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_take;

  // The front end classifies each transaction as a fetch, a store, or a
  // restart for a load that falls outside the frame store.
  lbt_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .req_type_i     (req_type_i),
    .load_address_i (load_address_i),
    .load_value_i   (load_value_i),
    .cmd_o          (cmd),
    .cmd_valid_o    (cmd_valid),
    .cmd_take_i     (cmd_take)
  );

  // The back end owns the frame store, the output position and the result queue.
  lbt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (cmd),
    .cmd_valid_i  (cmd_valid),
    .cmd_take_o   (cmd_take),
    .empty_o      (empty),
    .pop_i        (pop),
    .out_byte_o   (out_byte_o),
    .packet_end_o (packet_end_o),
    .frame_last_o (frame_last_o)
  );

endmodule

[sv/lbt_checker.sv]
// Port-level checker for the LED strip bit transposer and its bind statement.
`include "led_strip_bit_transposer_macros.svh"

module lbt_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        full,
  input logic                        empty,
  input logic                        pop,
  input logic [lbt_pkg::DATA_W-1:0]  out_byte_o,
  input logic                        packet_end_o,
  input logic                        frame_last_o
);

  logic [lbt_pkg::DATA_W+1:0] result_head;

  assign result_head = {out_byte_o, packet_end_o, frame_last_o};

  // Both queues come out of reset empty.
  `LBT_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> (empty && !full), "queues busy in reset")

  // The end of a frame is also the end of the last latch packet.
  `LBT_ASSERT(a_last_ends_packet, (!empty && frame_last_o) |-> packet_end_o, "no packet end")

  // The frame end is a latch byte, so it carries zero.
  `LBT_ASSERT(a_last_is_zero, (!empty && frame_last_o) |-> (out_byte_o == '0), "latch byte set")

  // A waiting result stays put until it is popped.
  `LBT_ASSERT(a_result_stays, (!empty && !pop) |=> !empty, "waiting result lost")
  `LBT_ASSERT(a_result_holds, (!empty && !pop) |=> $stable(result_head), "waiting result changed")

endmodule

bind led_strip_bit_transposer lbt_checker u_lbt_checker (.*);
